@@ hdl/bitmap_page_frame_allocator_top_macros.svh @@
// Assertion macros shared by the allocator modules.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BPFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Signal must stay low outside reset.
`define BPFA_NEVER(lbl, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(sig)) else $error(msg);
`endif

@@ hdl/bpfa_pkg.sv @@
// Package: shared types, request codes and controller/datapath interface structs.
package bpfa_pkg;

  localparam int unsigned MaxPagesDef  = 32768;
  localparam int unsigned PageBytesDef = 4096;
  localparam int unsigned AddrBitsDef  = 48;

  localparam logic [2:0] ReqAlloc    = 3'd0;
  localparam logic [2:0] ReqFree     = 3'd1;
  localparam logic [2:0] ReqMarkUsed = 3'd2;
  localparam logic [2:0] ReqMarkFree = 3'd3;
  localparam logic [2:0] ReqTest     = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] alloc_pages;
    logic [47:0] range_base;
    logic [47:0] range_limit;
    logic [14:0] page_index;
  } req_t;

  typedef struct packed {
    logic        success;
    logic [47:0] alloc_address;
    logic        page_used;
  } rsp_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;       // capture request
    logic calc;       // compute page bounds (after load)
    logic clr_init;   // clearing pass write
    logic rd;         // issue memory read of current word
    logic wr;         // merge & write current word
    logic scan;       // consume one chunk of read data for alloc search
    logic next;       // advance word pointer
    logic mark_run;   // set up range write for found run
    logic rsp;        // emit result
  } cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic init_last;
    logic range_empty;
    logic word_last;
    logic found;
    logic scan_end;
    logic chunk_last;
  } sts_t;

endpackage

@@ hdl/bpfa_datapath.sv @@
// Datapath: bitmap memory, range arithmetic, word walker and run search.
module bpfa_datapath #(
  parameter int unsigned MaxPages  = bpfa_pkg::MaxPagesDef,
  parameter int unsigned PageBytes = bpfa_pkg::PageBytesDef,
  parameter int unsigned AddrBits  = bpfa_pkg::AddrBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bpfa_pkg::req_t   req_i,
  input  logic [15:0]      total_pages_i,
  input  bpfa_pkg::cmd_t   cmd_i,
  output bpfa_pkg::sts_t   sts_o,
  output bpfa_pkg::rsp_t   rsp_o,
  output logic             rsp_valid_o
);
  import bpfa_pkg::*;
  `include "bitmap_page_frame_allocator_top_macros.svh"

  localparam int unsigned Words = (MaxPages + 63) / 64;
  localparam int unsigned WW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned PW    = $clog2(MaxPages) + 1;   // holds MaxPages
  localparam int unsigned SH    = $clog2(PageBytes);
  localparam logic [63:0] AddrMax = ~64'd0 >> (64 - AddrBits);

  // Bitmap memory, read data registered.
  logic [63:0] mem_q [Words];
  logic [63:0] rdata_q;

  req_t        req_q;
  logic [PW-1:0] first_q, last_q;   // page range [first,last)
  logic [PW-1:0] lim_q;
  logic [WW-1:0] wptr_q;
  logic [2:0]    chunk_q;          // eight-page chunk of the word under scan
  logic [PW-1:0] run_q;
  logic [PW-1:0] end_q;            // page after found run
  logic          found_q;
  rsp_t          rsp_q;
  logic          rsp_valid_q;

  // Effective limit.
  logic [PW-1:0] lim_d;
  always_comb begin
    if ({16'd0, total_pages_i} < 32'(MaxPages)) lim_d = PW'(total_pages_i);
    else lim_d = PW'(MaxPages);
  end

  // Range bounds in pages (64 bit intermediates, then clamped).
  logic [63:0] base_m, lim_m, sum_s, f64, l64;
  logic [64:0] sum_w;
  always_comb begin
    base_m = {16'd0, req_q.range_base} & AddrMax;
    lim_m  = {16'd0, req_q.range_limit} & AddrMax;
    if (req_q.req_type == ReqFree) sum_w = {1'b0, base_m} + 65'(PageBytes);
    else sum_w = {1'b0, base_m} + {1'b0, lim_m};
    sum_s = (sum_w[64] || sum_w[63:0] > AddrMax) ? AddrMax : sum_w[63:0];
    if (req_q.req_type == ReqMarkUsed) begin
      f64 = base_m >> SH;
      l64 = (lim_m >> SH) + 64'(|lim_m[SH-1:0]);
    end else begin
      f64 = (base_m >> SH) + 64'(|base_m[SH-1:0]);
      l64 = sum_s >> SH;
    end
  end

  // Mask of pages in current word within [first,last) and below limit.
  logic [63:0] wmask;
  logic [PW-1:0] hi;
  always_comb begin
    hi = (last_q > lim_q) ? lim_q : last_q;
    for (int i = 0; i < 64; i++) begin
      wmask[i] = (PW'({wptr_q, 6'(i)}) >= first_q) && (PW'({wptr_q, 6'(i)}) < hi);
    end
  end

  // Run search over one eight-page chunk of the registered word per cycle while scan is asserted.
  logic [PW-1:0] run_n;
  logic          hit;
  logic [PW-1:0] hit_end;
  always_comb begin
    logic [PW-1:0] r;
    logic          h;
    logic [PW-1:0] e;
    logic [PW-1:0] pg;
    r = run_q; h = 1'b0; e = '0; pg = '0;
    for (int i = 0; i < 8; i++) begin
      pg = PW'({wptr_q, chunk_q, 3'(i)});
      if (!h) begin
        if (rdata_q[{chunk_q, 3'(i)}] || (pg >= lim_q)) r = '0;
        else r = r + 1'b1;
        if ((r == PW'(req_q.alloc_pages)) && (pg < lim_q)) begin
          h = 1'b1;
          e = pg + 1'b1;
        end
      end
    end
    run_n = r; hit = h; hit_end = e;
  end

  // Result fields for the current request.
  rsp_t        rsp_d;
  logic [63:0] addr_w;
  always_comb begin
    addr_w = {{(64-PW){1'b0}}, first_q} << SH;
    rsp_d  = '0;
    case (req_q.req_type)
      ReqAlloc: begin
        rsp_d.success = (req_q.alloc_pages == 16'd0) || found_q;
        if (found_q && req_q.alloc_pages != 16'd0)
          rsp_d.alloc_address = 48'((addr_w > AddrMax) ? AddrMax : addr_w);
      end
      ReqFree, ReqMarkUsed, ReqMarkFree: rsp_d.success = 1'b1;
      ReqTest: begin
        rsp_d.success = 1'b1;
        rsp_d.page_used = ({1'b0, req_q.page_index} >= 16'(lim_q)) ||
                          rdata_q[req_q.page_index[5:0]];
      end
      default: rsp_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_init) mem_q[wptr_q] <= '1;
    else if (cmd_i.wr) begin
      if (req_q.req_type == ReqMarkFree || req_q.req_type == ReqFree)
        mem_q[wptr_q] <= rdata_q & ~wmask;
      else mem_q[wptr_q] <= rdata_q | wmask;
    end
    if (cmd_i.rd) rdata_q <= mem_q[wptr_q];
    if (cmd_i.load) req_q <= req_i;
  end

  // Control-related registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0; first_q <= '0; last_q <= '0; lim_q <= '0; chunk_q <= '0;
      run_q <= '0; found_q <= 1'b0; end_q <= '0; rsp_valid_q <= 1'b0;
      rsp_q <= '0;
    end else begin
      rsp_valid_q <= cmd_i.rsp;
      if (cmd_i.load) begin
        lim_q <= lim_d; run_q <= '0; found_q <= 1'b0; chunk_q <= '0;
        // Test reads the word holding its page; alloc starts at word 0, range ops are repointed by calc
        wptr_q <= (req_i.req_type == ReqTest) ? WW'(req_i.page_index >> 6) : '0;
      end
      if (cmd_i.calc) begin
        first_q <= (f64 > 64'(MaxPages)) ? PW'(MaxPages) : PW'(f64);
        last_q  <= (l64 > 64'(MaxPages)) ? PW'(MaxPages) : PW'(l64);
        wptr_q  <= (f64 >= 64'(MaxPages)) ? '0 : WW'(f64 >> 6);
      end
      if (cmd_i.scan) begin
        run_q   <= run_n;
        chunk_q <= chunk_q + 1'b1;
        if (hit) begin found_q <= 1'b1; end_q <= hit_end; end
      end
      if (cmd_i.mark_run) begin
        first_q <= end_q - PW'(req_q.alloc_pages);
        last_q  <= end_q;
        wptr_q  <= WW'((end_q - PW'(req_q.alloc_pages)) >> 6);
      end
      if (cmd_i.next) wptr_q <= wptr_q + 1'b1;
      if (cmd_i.rsp) rsp_q <= rsp_d;
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  logic [PW-1:0] first_clamp;
  assign first_clamp = (first_q > lim_q) ? lim_q : first_q;

  always_comb begin
    sts_o.init_last   = (wptr_q == WW'(Words - 1));
    sts_o.range_empty = (first_clamp >= hi);
    sts_o.word_last   = ({wptr_q, 6'd63} >= (WW+6)'(hi - 1'b1));
    sts_o.found       = found_q;
    sts_o.scan_end    = ({1'b0, wptr_q, 6'd63} >= (WW+7)'(lim_q)) ||
                        (wptr_q == WW'(Words - 1));
    sts_o.chunk_last  = (chunk_q == 3'd7);
  end

  `BPFA_NEVER(a_rd_wr_excl, cmd_i.rd && cmd_i.wr, "read and write in one cycle")
  `BPFA_ASSERT(a_rsp_pulse, rsp_valid_o |=> !rsp_valid_o, "result held over two cycles")
  `BPFA_ASSERT(a_fail_zero, rsp_valid_o && !rsp_o.success |-> rsp_o.alloc_address == '0,
               "failed result with address")
endmodule

@@ hdl/bpfa_ctrl.sv @@
// Controller state machine sequencing clear, search and range writes.
module bpfa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [2:0]     req_type_i,
  input  logic [15:0]    alloc_pages_i,
  input  bpfa_pkg::sts_t sts_i,
  output bpfa_pkg::cmd_t cmd_o,
  output logic           busy_o
);
  import bpfa_pkg::*;
  `include "bitmap_page_frame_allocator_top_macros.svh"

  typedef enum logic [3:0] {
    StInit, StIdle, StCalc, StRngRd, StRngWr, StScanRd, StScan, StRunSet,
    StTestRd, StResp
  } state_e;

  state_e state_q, state_d;
  logic [2:0] typ_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StInit: begin
        cmd_o.clr_init = 1'b1;
        cmd_o.next = 1'b1;
        if (sts_i.init_last) state_d = StIdle;
      end
      StIdle: if (start_i) begin
        cmd_o.load = 1'b1;
        if (req_type_i == ReqAlloc && alloc_pages_i == 16'd0) state_d = StResp;
        else if (req_type_i == ReqAlloc) state_d = StScanRd;
        else if (req_type_i == ReqTest) state_d = StTestRd;
        else if (req_type_i inside {ReqFree, ReqMarkUsed, ReqMarkFree}) state_d = StCalc;
        else state_d = StResp;
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        state_d = StRngRd;
      end
      StRngRd: begin
        if (sts_i.range_empty) state_d = StResp;
        else begin cmd_o.rd = 1'b1; state_d = StRngWr; end
      end
      StRngWr: begin
        cmd_o.wr = 1'b1;
        if (sts_i.word_last) state_d = StResp;
        else begin cmd_o.next = 1'b1; state_d = StRngRd; end
      end
      StScanRd: begin
        cmd_o.rd = 1'b1;
        state_d = StScan;
      end
      // Eight chunks per word; the search stops once a run is found
      StScan: begin
        if (sts_i.found) state_d = StRunSet;
        else begin
          cmd_o.scan = 1'b1;
          if (!sts_i.chunk_last) state_d = StScan;
          else if (sts_i.scan_end) state_d = StRunSet;
          else begin cmd_o.next = 1'b1; state_d = StScanRd; end
        end
      end
      StRunSet: begin
        if (sts_i.found) begin cmd_o.mark_run = 1'b1; state_d = StRngRd; end
        else state_d = StResp;
      end
      StTestRd: begin
        cmd_o.rd = 1'b1;
        state_d = StResp;
      end
      StResp: begin
        cmd_o.rsp = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      typ_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load) typ_q <= req_type_i;
    end
  end

  assign busy_o = (state_q != StIdle);

  `BPFA_ASSERT(a_load_idle, cmd_o.load |-> state_q == StIdle, "load outside idle")
  `BPFA_ASSERT(a_rsp_idle, cmd_o.rsp |=> !busy_o, "not idle after result")
  `BPFA_ASSERT(a_wr_type, cmd_o.wr |-> typ_q != ReqTest, "write during test")
endmodule

@@ hdl/bitmap_page_frame_allocator_top.sv @@
// Top level: APB register, controller and datapath of the page allocator.
// One request at a time, busy high meanwhile.
// Result on done_o for one cycle, the first idle cycle; the receiver cannot stall.
// Reset: a clearing pass over every bitmap word marks all pages used (busy high).
module bitmap_page_frame_allocator_top #(
  parameter int unsigned MaxPages  = bpfa_pkg::MaxPagesDef,
  parameter int unsigned PageBytes = bpfa_pkg::PageBytesDef,
  parameter int unsigned AddrBits  = bpfa_pkg::AddrBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bpfa_pkg::req_t req_i,
  output logic           done_o,
  output bpfa_pkg::rsp_t rsp_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic           paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import bpfa_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [15:0] total_pages_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) total_pages_q <= '0;
    else if (psel && penable && pwrite && !paddr) total_pages_q <= pwdata[15:0];
  end
  assign pready = 1'b1;
  assign prdata = paddr ? 32'd0 : {16'd0, total_pages_q};

  bpfa_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .req_type_i(req_i.req_type),
    .alloc_pages_i(req_i.alloc_pages), .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  bpfa_datapath #(.MaxPages(MaxPages), .PageBytes(PageBytes), .AddrBits(AddrBits)) u_dp (
    .clk_i, .rst_ni, .req_i, .total_pages_i(total_pages_q), .cmd_i(cmd),
    .sts_o(sts), .rsp_o, .rsp_valid_o(done_o)
  );
endmodule

@@ test/tb_bitmap_page_frame_allocator_top.sv @@
// Testbench for the page frame allocator: random and directed requests checked against a bitmap model.
module tb_bitmap_page_frame_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bpfa_pkg::*;

  localparam int unsigned NumPages = MaxPagesDef;
  localparam longint unsigned PgBytes = PageBytesDef;
  localparam longint unsigned AddrMax = (64'd1 << AddrBitsDef) - 1;
  localparam logic [2:0] ReqBad5 = 3'd5;
  localparam logic [2:0] ReqBad6 = 3'd6;
  localparam logic [2:0] ReqBad7 = 3'd7;
  localparam logic RegTotalPages = 1'b0;
  localparam logic RegUnused = 1'b1;

  // Frame bitmap mirror: predicts each response and checks what comes out
  class frame_map_model;
    bit used_map [NumPages];
    longint unsigned total_pages;
    rsp_t pending_rsp[$];
    int mismatches;

    function new();
      foreach (used_map[i]) used_map[i] = 1'b1;
      total_pages = 0;
      mismatches = 0;
    endfunction

    function longint unsigned page_limit();
      return (total_pages < NumPages) ? total_pages : NumPages;
    endfunction

    function bit is_used(longint unsigned p);
      if (p >= page_limit()) return 1'b1;
      return used_map[p];
    endfunction

    function void write_range(longint unsigned first, longint unsigned last, bit val);
      longint unsigned lim;
      lim = page_limit();
      if (last > lim) last = lim;
      for (longint unsigned p = first; p < last; p++) used_map[p] = val;
    endfunction

    function longint unsigned ceil_pg(longint unsigned a);
      return a / PgBytes + ((a % PgBytes) != 0 ? 1 : 0);
    endfunction

    function void free_bytes(longint unsigned base, longint unsigned len);
      longint unsigned s;
      s = base + len;
      if (s > AddrMax) s = AddrMax;
      write_range(ceil_pg(base), s / PgBytes, 1'b0);
    endfunction

    // Note an accepted request and queue its response
    function void note_request(req_t r);
      rsp_t o;
      longint unsigned lim, run, n;
      o = '0;
      case (r.req_type)
        ReqAlloc: begin
          n = 64'(r.alloc_pages);
          if (n == 0) begin
            o.success = 1'b1;
          end else begin
            lim = page_limit();
            run = 0;
            for (longint unsigned p = 0; p < lim; p++) begin
              run = is_used(p) ? 0 : run + 1;
              if (run == n) begin
                write_range(p + 1 - n, p + 1, 1'b1);
                o.success = 1'b1;
                o.alloc_address = 48'((p + 1 - n) * PgBytes);
                break;
              end
            end
          end
        end
        ReqFree: begin
          free_bytes(r.range_base, PgBytes);
          o.success = 1'b1;
        end
        ReqMarkUsed: begin
          write_range(r.range_base / PgBytes, ceil_pg(r.range_limit), 1'b1);
          o.success = 1'b1;
        end
        ReqMarkFree: begin
          free_bytes(r.range_base, r.range_limit);
          o.success = 1'b1;
        end
        ReqTest: begin
          o.page_used = is_used(r.page_index);
          o.success = 1'b1;
        end
        default: ;
      endcase
      pending_rsp.push_back(o);
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
        return;
      end
      exp_rsp = pending_rsp.pop_front();
      if (got.success !== exp_rsp.success || got.alloc_address !== exp_rsp.alloc_address ||
          got.page_used !== exp_rsp.page_used) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp success=%0d addr=%h used=%0d, got success=%0d addr=%h used=%0d",
                   exp_rsp.success, exp_rsp.alloc_address, exp_rsp.page_used,
                   got.success, got.alloc_address, got.page_used);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  frame_map_model frame_map = new();
  bit idle_on = 1'b1;

  bitmap_page_frame_allocator_top dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o, .rsp_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Response monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) frame_map.check_response(rsp_o);
  end

  // Watchdog
  initial begin
    #300ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Launch one request and hold it until the block takes it
  task automatic issue(req_t r);
    req_i <= r;
    start <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (start && !busy) break;
    end
    frame_map.note_request(r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Drain all outstanding transactions before touching the register
  task automatic drain();
    start <= 1'b0;
    while (frame_map.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(logic addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == RegTotalPages) frame_map.total_pages = 64'(data[15:0]);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic req_t mk(logic [2:0] t, logic [15:0] n, logic [47:0] b,
                              logic [47:0] l, logic [14:0] pi);
    req_t r;
    r.req_type = t;
    r.alloc_pages = n;
    r.range_base = b;
    r.range_limit = l;
    r.page_index = pi;
    return r;
  endfunction

  // Random request, mostly aimed at pages inside the managed range
  function automatic req_t rand_request(int unsigned lim);
    req_t r;
    int unsigned sel;
    longint unsigned pg, cnt;
    r = mk(3'($urandom()), 16'($urandom()), rand48(), rand48(), 15'($urandom()));
    sel = $urandom_range(0, 99);
    pg = 64'($urandom_range(0, lim + 2));
    cnt = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, lim + 2))
                                      : 64'($urandom_range(0, 40));
    if (sel < 30) begin
      r.req_type = ReqAlloc;
      if ($urandom_range(0, 19) != 0)
        r.alloc_pages = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 70))
                                                    : 16'($urandom_range(1, 8));
    end else if (sel < 45) begin
      r.req_type = ReqFree;
      if ($urandom_range(0, 9) != 0)
        r.range_base = 48'(pg * PgBytes + ($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : 0));
    end else if (sel < 60) begin
      r.req_type = ReqMarkUsed;
      if ($urandom_range(0, 9) != 0) begin
        r.range_base = 48'(pg * PgBytes + ($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : 0));
        r.range_limit = ($urandom_range(0, 9) == 0) ? r.range_base - $urandom_range(0, 9000)
                      : 48'(r.range_base + cnt * PgBytes + $urandom_range(0, 1) * $urandom_range(0, 4095));
      end
    end else if (sel < 82) begin
      r.req_type = ReqMarkFree;
      if ($urandom_range(0, 9) != 0) begin
        r.range_base = 48'(pg * PgBytes + ($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : 0));
        r.range_limit = 48'(cnt * PgBytes + $urandom_range(0, 1) * $urandom_range(0, 4095));
      end
    end else if (sel < 96) begin
      r.req_type = ReqTest;
      if ($urandom_range(0, 9) != 0) r.page_index = 15'($urandom_range(0, lim + 1));
    end else begin
      r.req_type = 3'($urandom_range(ReqBad5, ReqBad7));
    end
    return r;
  endfunction

  initial begin
    int unsigned phase_pages [7];
    int unsigned lim;
    phase_pages = '{64, 1, 300, 32768, 65535, 1000, 150};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: nothing managed yet
    issue(mk(ReqTest, 16'd0, '0, '0, 15'd0));
    issue(mk(ReqAlloc, 16'd0, '0, '0, 15'd0));
    issue(mk(ReqAlloc, 16'd1, '0, '0, 15'd0));
    issue(mk(ReqMarkFree, 16'd0, '0, 48'd409600, 15'd0));
    issue(mk(ReqBad5, 16'hFFFF, '1, '1, '1));
    drain();
    apb_write(RegUnused, 32'd77);
    apb_write(RegTotalPages, 32'd200);

    // Directed: 200 pages
    issue(mk(ReqTest, 16'd0, '0, '0, 15'd0));
    issue(mk(ReqMarkFree, 16'd0, '0, 48'd819200, 15'd0));
    issue(mk(ReqTest, 16'd0, '0, '0, 15'd199));
    issue(mk(ReqTest, 16'd0, '0, '0, 15'd200));
    issue(mk(ReqAlloc, 16'd1, '0, '0, 15'd0));
    issue(mk(ReqAlloc, 16'd5, '0, '0, 15'd0));
    issue(mk(ReqFree, 16'd0, 48'd0, '0, 15'd0));
    issue(mk(ReqFree, 16'd0, 48'd4097, '0, 15'd0));
    issue(mk(ReqMarkUsed, 16'd0, 48'd5000, 48'd20481, 15'd0));
    issue(mk(ReqMarkFree, 16'd0, 48'd5000, 48'd20000, 15'd0));
    issue(mk(ReqMarkUsed, 16'd0, 48'd40960, 48'd8192, 15'd0));
    issue(mk(ReqMarkFree, 16'd0, '1, '1, 15'd0));
    issue(mk(ReqMarkUsed, 16'd0, '1, '1, 15'd0));
    issue(mk(ReqAlloc, 16'd201, '0, '0, 15'd0));
    issue(mk(ReqAlloc, 16'hFFFF, '0, '0, 15'd0));
    issue(mk(ReqTest, 16'd0, '0, '0, 15'h7FFF));
    issue(mk(ReqBad6, 16'd3, '0, '0, 15'd0));
    issue(mk(ReqBad7, 16'd3, '0, '0, 15'd0));
    issue(mk(ReqAlloc, 16'd0, '1, '1, '1));

    // Random phases over several limits; the last one runs without idling
    foreach (phase_pages[i]) begin
      drain();
      apb_write(RegTotalPages, phase_pages[i]);
      lim = (phase_pages[i] < NumPages) ? phase_pages[i] : NumPages;
      if (i == 6) idle_on = 1'b0;
      repeat ((lim > 4000) ? 60 : 150) issue(rand_request(lim));
    end

    // Wait out all responses, then keep watching for stray ones before the verdict
    start <= 1'b0;
    while (frame_map.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
    if (frame_map.mismatches == 0 && frame_map.pending_rsp.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/bpfa_pkg.sv
hdl/bpfa_datapath.sv
hdl/bpfa_ctrl.sv
hdl/bitmap_page_frame_allocator_top.sv
test/tb_bitmap_page_frame_allocator_top.sv
